>>> design/block_peak_agc_core_defines.svh
// Assertion macros shared by the block peak AGC checker.
`ifndef BLOCK_PEAK_AGC_CORE_DEFINES_SVH
`define BLOCK_PEAK_AGC_CORE_DEFINES_SVH

// Clocked check, off while reset is low.
`define BPAGC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("block peak agc check failed");

// Clocked check that also holds through reset.
`define BPAGC_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) (prop)) \
        else $error("block peak agc reset check failed");

`endif

>>> design/bpagc_pkg.sv
// Types and constants of the block peak AGC.
`default_nettype none
package bpagc_pkg;

    localparam int DATA_W         = 32;
    localparam int BLOCK_LEN_LOG2 = 7;
    localparam int BLOCK_LEN      = 1 << BLOCK_LEN_LOG2;
    localparam int ADDR_W         = BLOCK_LEN_LOG2;
    localparam int TIME_W         = 16;
    localparam int STRENGTH_W     = 31;
    localparam int TDATA_W        = 64;
    localparam int CFG_IDX_W      = 2;
    localparam int MUL_W          = DATA_W + 1;
    localparam int PROD_W         = 2 * MUL_W;
    localparam int STEP_MUL       = 30;
    localparam int STEP_PROD_W    = TIME_W + 5;
    localparam int STEP_SHIFT     = 6 + BLOCK_LEN_LOG2;
    localparam int DIV_CNT_W      = $clog2(DATA_W);

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK = CFG_IDX_W'(0);

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_result_t;

endpackage
`default_nettype wire

>>> design/bpagc_dly.sv
// Delay line memory with per-entry valid bits; read-before-write on one port.
`default_nettype none
module bpagc_dly
    import bpagc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0]    mem [BLOCK_LEN];
    logic [BLOCK_LEN-1:0] valid_reg;
    logic [DATA_W-1:0]    rd_raw_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rd_raw_reg <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else if (en) begin
            rd_vld_reg      <= valid_reg[addr];
            valid_reg[addr] <= 1'b1;
        end
    end

    // never-written entries read as zero
    assign rdata = rd_vld_reg ? rd_raw_reg : '0;

endmodule
`default_nettype wire

>>> design/bpagc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module bpagc_div
    import bpagc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] dividend,
    input  wire logic [DATA_W-1:0] divisor,
    output div_result_t            result
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DATA_W-1:0]    rem_reg;
    logic [DATA_W-1:0]    quo_reg;
    logic [DATA_W-1:0]    dsr_reg;
    logic [DATA_W:0]      rem_sh;
    logic                 fits;

    assign rem_sh = {rem_reg, quo_reg[DATA_W-1]};
    assign fits   = rem_sh >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DATA_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out of the top of quo_reg as quotient bits shift in
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= DATA_W'(rem_sh - {1'b0, dsr_reg});
            end else begin
                rem_reg <= rem_sh[DATA_W-1:0];
            end
            quo_reg <= {quo_reg[DATA_W-2:0], fits};
        end
    end

    assign result.done     = done_reg;
    assign result.quotient = quo_reg;

endmodule
`default_nettype wire

>>> design/bpagc_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none
module bpagc_mul
    import bpagc_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic signed [MUL_W-1:0]  a,
    input  wire logic signed [MUL_W-1:0]  b,
    output logic      signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

>>> design/block_peak_agc_core.sv
// Top level of the block peak AGC: sequencer, gain state and stream ports.
// An ordinary sample passes through the MUL, SCALE and DONE states; a new input is taken only
// once its result has been loaded for the receiver and the sequencer is back in idle.
// A block-closing sample also runs a serial division for the target and, when the gain rises,
// a second one for the step, then squaring; the step division is skipped otherwise.
// Synchronous active-low reset clears state and valid bits; ready right after reset.
`default_nettype none
module block_peak_agc_core
    import bpagc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TIME_W-1:0]    cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [DATA_W-1:0]    s_tdata,   // [31:0] sample_in
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [TDATA_W-1:0]   m_tdata,   // [31:0] sample_out, [62:32] signal_strength
    output logic      [0:0]           m_tuser    // [0] block_end
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL   = 9'b000000010,
        S_SCALE = 9'b000000100,
        S_DIV1  = 9'b000001000,
        S_CMP   = 9'b000010000,
        S_DIV2  = 9'b000100000,
        S_SQR   = 9'b001000000,
        S_SQW   = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]     wptr_reg;
    logic                  wrap_reg;
    logic [DATA_W-1:0]     run_peak_reg;
    logic [DATA_W-1:0]     blk_peak_reg;
    logic [DATA_W-1:0]     gain_reg;
    logic [DATA_W-1:0]     target_reg;
    logic [STRENGTH_W-1:0] strength_reg;
    logic [DATA_W-1:0]     scaled_reg;
    logic [TIME_W-1:0]     attack_reg;
    logic                  out_valid_reg;
    logic [DATA_W-1:0]     out_sample_reg;
    logic [STRENGTH_W-1:0] out_strength_reg;
    logic                  out_end_reg;

    logic                     in_xfer;
    logic                     out_load;
    logic [DATA_W-1:0]        old_sample;
    logic [DATA_W-1:0]        in_mag;
    logic                     mul_en;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [DATA_W*2-1:0] prod64;
    logic signed [DATA_W*2-1:0] half;
    logic [DATA_W-1:0]        scaled_sat;
    logic [DATA_W-1:0]        gain_eff;
    logic [STEP_PROD_W-1:0]   step_prod;
    logic [STEP_PROD_W-1:0]   steps_raw;
    logic [DATA_W-1:0]        steps;
    logic                     div_start;
    logic [DATA_W-1:0]        div_dividend;
    logic [DATA_W-1:0]        div_divisor;
    div_result_t              div_res;

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    bpagc_dly u_dly (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (in_xfer),
        .addr    (wptr_reg),
        .wdata   (s_tdata),
        .rdata   (old_sample)
    );

    assign mul_en = (state_reg == S_MUL) || (state_reg == S_SQR);

    always_comb begin
        if (state_reg == S_SQR) begin
            mul_a = $signed({{(MUL_W-16){1'b0}}, blk_peak_reg[DATA_W-1:16]});
            mul_b = $signed({{(MUL_W-16){1'b0}}, blk_peak_reg[DATA_W-1:16]});
        end else begin
            mul_a = $signed({old_sample[DATA_W-1], old_sample});
            mul_b = $signed({1'b0, gain_reg});
        end
    end

    bpagc_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // halve toward zero, then saturate to 32-bit signed
    assign prod64 = prod[DATA_W*2-1:0];
    assign half   = $signed(prod64 + {{(DATA_W*2-1){1'b0}}, prod64[DATA_W*2-1]}) >>> 1;

    always_comb begin
        if (!half[DATA_W*2-1] && (|half[DATA_W*2-2:DATA_W-1])) begin
            scaled_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (half[DATA_W*2-1] && !(&half[DATA_W*2-2:DATA_W-1])) begin
            scaled_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            scaled_sat = half[DATA_W-1:0];
        end
    end

    assign in_mag   = s_tdata[DATA_W-1] ? (~s_tdata + 1'b1) : s_tdata;
    assign gain_eff = (gain_reg == '0) ? DATA_W'(1) : gain_reg;

    assign step_prod = STEP_PROD_W'(attack_reg) * STEP_PROD_W'(STEP_MUL);
    assign steps_raw = step_prod >> STEP_SHIFT;
    assign steps     = (steps_raw == '0) ? DATA_W'(1) : DATA_W'(steps_raw);

    // divider: target = 2^31 / peak, then step = (target - gain) / steps
    assign div_start = ((state_reg == S_SCALE) && wrap_reg)
                    || ((state_reg == S_CMP) && (target_reg > gain_eff));

    always_comb begin
        if (state_reg == S_CMP) begin
            div_dividend = target_reg - gain_eff;
            div_divisor  = steps;
        end else begin
            div_dividend = {1'b1, {(DATA_W-1){1'b0}}};
            div_divisor  = run_peak_reg;
        end
    end

    bpagc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .result   (div_res)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_xfer) state_next = S_MUL;
            S_MUL:   state_next = S_SCALE;
            S_SCALE: state_next = wrap_reg ? S_DIV1 : S_DONE;
            S_DIV1:  if (div_res.done) state_next = S_CMP;
            S_CMP:   state_next = (target_reg > gain_eff) ? S_DIV2 : S_SQR;
            S_DIV2:  if (div_res.done) state_next = S_SQR;
            S_SQR:   state_next = S_SQW;
            S_SQW:   state_next = S_DONE;
            S_DONE:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            wptr_reg      <= '0;
            wrap_reg      <= 1'b0;
            run_peak_reg  <= DATA_W'(1);
            blk_peak_reg  <= '0;
            gain_reg      <= '0;
            strength_reg  <= '0;
            attack_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            // only the attack time matters: when the target does not exceed the
            // gain, the clamp lands the gain on the target whatever the step count
            if (cfg_we && (cfg_index == CFG_ATTACK)) begin
                attack_reg <= cfg_data;
            end

            if (in_xfer) begin
                wptr_reg <= wptr_reg + 1'b1;
                wrap_reg <= (wptr_reg == ADDR_W'(BLOCK_LEN - 1));
                if (in_mag > run_peak_reg) begin
                    run_peak_reg <= in_mag;
                end
            end

            if ((state_reg == S_SCALE) && wrap_reg) begin
                blk_peak_reg <= run_peak_reg;
                run_peak_reg <= DATA_W'(1);
            end

            if (state_reg == S_CMP) begin
                gain_reg <= (target_reg > gain_eff) ? gain_eff : target_reg;
            end

            if ((state_reg == S_DIV2) && div_res.done) begin
                gain_reg <= gain_reg + div_res.quotient;
            end

            if (state_reg == S_SQW) begin
                strength_reg <= prod[STRENGTH_W-1:0];
            end

            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_SCALE) begin
            scaled_reg <= scaled_sat;
        end
        if ((state_reg == S_DIV1) && div_res.done) begin
            target_reg <= div_res.quotient;
        end
        if (out_load) begin
            out_sample_reg   <= scaled_reg;
            out_strength_reg <= strength_reg;
            out_end_reg      <= wrap_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_strength_reg, out_sample_reg};
    assign m_tuser  = out_end_reg;

endmodule
`default_nettype wire

>>> design/bpagc_chk.sv
// Port-level checks of the block peak AGC, bound to the top level.
`default_nettype none
`include "block_peak_agc_core_defines.svh"
module bpagc_chk
    import bpagc_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [TDATA_W-1:0]   m_tdata,
    input wire logic [0:0]           m_tuser
);

    // a stalled result holds
    `BPAGC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // one sample at a time: input closes right after a transfer
    `BPAGC_ASSERT(a_in_busy, s_tvalid && s_tready |=> !s_tready)

    // a fresh result is loaded only as the sequencer returns to idle
    `BPAGC_ASSERT(a_out_rise, $rose(m_tvalid) |-> s_tready)

    // reset leaves no result pending and the input open
    `BPAGC_ASSERT_RST(a_reset, !aresetn |=> !m_tvalid && s_tready)

endmodule

bind block_peak_agc_core bpagc_chk u_bpagc_chk (.*);
`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the block peak AGC core: streams samples and checks every result.
module tb;
    import bpagc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);
    localparam logic [DATA_W-1:0]    FULL_SCALE  = 32'h8000_0000;
    localparam logic [TIME_W-1:0]    TIME_MAX    = 16'hFFFF;
    localparam int                   SETTLE_CYCLES = 150;
    localparam int                   STALL_CYCLES  = 400;

    typedef struct {
        logic [DATA_W-1:0]     sample_out;
        logic [STRENGTH_W-1:0] strength;
        logic                  block_end;
    } agc_result_t;

    class agc_scoreboard;
        logic [DATA_W-1:0]     line_mem [BLOCK_LEN];
        logic [ADDR_W-1:0]     wr_pos;
        logic [DATA_W-1:0]     run_peak;
        logic [DATA_W-1:0]     blk_peak;
        logic [DATA_W-1:0]     gain;
        logic [STRENGTH_W-1:0] strength;
        logic [TIME_W-1:0]     attack_t;
        logic [TIME_W-1:0]     release_t;
        agc_result_t           expected_q[$];
        int                    mismatches;
        int                    result_idx;

        function new();
            foreach (line_mem[i]) line_mem[i] = '0;
            wr_pos     = '0;
            run_peak   = 32'd1;
            blk_peak   = '0;
            gain       = '0;
            strength   = '0;
            attack_t   = '0;
            release_t  = '0;
            mismatches = 0;
            result_idx = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
            if (idx == CFG_ATTACK) begin
                attack_t = val;
            end else if (idx == CFG_RELEASE) begin
                release_t = val;
            end
        endfunction

        // Move the gain toward full scale over the block peak, then refresh strength.
        function void close_block();
            logic [DATA_W-1:0] target;
            logic [DATA_W-1:0] steps;
            logic [DATA_W-1:0] peak_hi;
            logic [TIME_W-1:0] tsel;
            longint            next_g;
            blk_peak = run_peak;
            run_peak = 32'd1;
            if (gain == '0) gain = 32'd1;
            target = FULL_SCALE / blk_peak;
            tsel   = (target > gain) ? attack_t : release_t;
            steps  = (32'(tsel) * STEP_MUL) >> STEP_SHIFT;
            if (steps == '0) steps = 32'd1;
            next_g = longint'(gain) + (longint'(target) - longint'(gain)) / longint'(steps);
            if (next_g > longint'(target)) next_g = longint'(target);
            if (next_g < 0) next_g = 0;
            gain     = next_g[DATA_W-1:0];
            peak_hi  = blk_peak >> 16;
            strength = STRENGTH_W'(peak_hi * peak_hi);
        endfunction

        function void note_sample(logic [DATA_W-1:0] s);
            longint      old_v;
            longint      cur_v;
            longint      prod;
            logic [DATA_W-1:0] mag;
            agc_result_t r;
            old_v = longint'($signed(line_mem[wr_pos]));
            cur_v = longint'($signed(s));
            line_mem[wr_pos] = s;
            mag = (cur_v < 0) ? DATA_W'(-cur_v) : s;
            if (mag > run_peak) run_peak = mag;
            prod = (old_v * longint'(gain)) / 2;
            if (prod > 64'sh7FFF_FFFF) prod = 64'sh7FFF_FFFF;
            if (prod < -64'sh8000_0000) prod = -64'sh8000_0000;
            r.sample_out = prod[DATA_W-1:0];
            r.block_end  = 1'b0;
            wr_pos = wr_pos + 1'b1;
            if (wr_pos == '0) begin
                close_block();
                r.block_end = 1'b1;
            end
            r.strength = strength;
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            mismatches++;
        endtask

        task check_result(logic [TDATA_W-1:0] data, logic [0:0] user);
            agc_result_t e;
            if (expected_q.size() == 0) begin
                report($sformatf("result %0d arrived with nothing pending", result_idx));
            end else begin
                e = expected_q.pop_front();
                if (data[31:0] !== e.sample_out)
                    report($sformatf("result %0d: sample_out %h, want %h",
                                     result_idx, data[31:0], e.sample_out));
                if (data[62:32] !== e.strength)
                    report($sformatf("result %0d: signal_strength %h, want %h",
                                     result_idx, data[62:32], e.strength));
                if (user[0] !== e.block_end)
                    report($sformatf("result %0d: block_end %b, want %b",
                                     result_idx, user[0], e.block_end));
            end
            result_idx++;
        endtask
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TIME_W-1:0]    cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic [0:0]           m_tuser;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic stall_go      = 1'b0;
    logic stall_hold    = 1'b0;

    agc_scoreboard sb = new();

    block_peak_agc_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Long receiver hold-off so the core fills up and backs up its input.
    initial begin
        wait (stall_go);
        @(posedge aclk);
        stall_hold = 1'b1;
        repeat (STALL_CYCLES) @(posedge aclk);
        stall_hold = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= !stall_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        sb.set_reg(idx, val);
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_sample(input logic [DATA_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_sample(value);
        @(negedge aclk);
    endtask

    // Drop valid, wait out every pending result, then let the gain update finish.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] mixed_sample();
        logic [DATA_W-1:0] r;
        int                pick;
        r    = $urandom;
        pick = $urandom_range(9);
        if (pick < 4) return r;
        if (pick < 8) return $signed(r) >>> $urandom_range(1, 30);
        if (pick == 8) begin
            case ($urandom_range(2))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                default: return 32'h8000_0001;
            endcase
        end
        return DATA_W'($urandom_range(2)) - 1;
    endfunction

    function automatic logic [DATA_W-1:0] tiny_sample();
        return DATA_W'($urandom_range(2)) - 1;
    endfunction

    function automatic logic [DATA_W-1:0] moderate_sample();
        logic [DATA_W-1:0] r;
        r = $urandom;
        return $signed(r) >>> $urandom_range(16, 24);
    endfunction

    logic [DATA_W-1:0] directed_q[$] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h8000_0001, 32'h0000_0002, 32'hFFFF_FFFE,
        32'h0001_0000, 32'hFFFF_0000, 32'h0000_FFFF, 32'hFFFF_0001,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h4000_0000, 32'hC000_0000,
        32'h0000_0003, 32'h1234_5678, 32'hEDCB_A988, 32'h7FFF_0000,
        32'h8001_0000, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_0000
    };

    // Phases line up with block boundaries: each one closes exactly one block.
    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // first block: extremes and mixed traffic, no smoothing
        write_reg(CFG_ATTACK, '0);
        write_reg(CFG_RELEASE, '0);
        send_idle_pct = 17;
        recv_idle_pct = 85;
        foreach (directed_q[i]) send_sample(directed_q[i]);
        repeat (BLOCK_LEN - directed_q.size()) send_sample(mixed_sample());
        drain_results();

        // quiet block: peak stays at one, gain jumps to full scale
        write_reg(CFG_ATTACK, '0);
        write_reg(CFG_RELEASE, TIME_MAX);
        send_idle_pct = 85;
        recv_idle_pct = 17;
        repeat (BLOCK_LEN) send_sample(tiny_sample());
        drain_results();

        // loud block under back-pressure, random smoothing times
        write_reg(CFG_ATTACK, TIME_W'($urandom));
        write_reg(CFG_RELEASE, TIME_W'($urandom));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_go = 1'b1;
        repeat (BLOCK_LEN) send_sample(mixed_sample());
        drain_results();

        // moderate block: slow attack; spare indexes must not disturb the times
        write_reg(CFG_ATTACK, TIME_MAX);
        write_reg(CFG_RELEASE, 16'd273);
        write_reg(CFG_SPARE_A, TIME_MAX);
        write_reg(CFG_SPARE_B, 16'hA5A5);
        repeat (BLOCK_LEN) send_sample(moderate_sample());
        drain_results();

        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
